// File: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, character codes and control structs for the interpreter core.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int PROG_DEPTH_DEF = 1024;
  localparam int TAPE_DEPTH_DEF = 1024;
  localparam int CALL_DEPTH_DEF = 8;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] load_addr;
    logic [7:0] load_byte;
    logic [7:0] in_byte;
    logic       in_valid;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_decimal;
    logic       waiting_input;
    logic       halted;
    logic       fault;
  } out_item_t;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  localparam logic [2:0] M_EXEC   = 3'd0;
  localparam logic [2:0] M_FWD    = 3'd1;
  localparam logic [2:0] M_BACK   = 3'd2;
  localparam logic [2:0] M_SEARCH = 3'd3;
  localparam logic [2:0] M_DEFEND = 3'd4;
  localparam logic [2:0] M_SKIP   = 3'd5;

  localparam logic [1:0] RD_A0 = 2'd0;
  localparam logic [1:0] RD_A1 = 2'd1;
  localparam logic [1:0] RD_A2 = 2'd2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       restart;
    logic       clr_step;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       tape_re;
    logic       cap0;
    logic       cap1;
    logic       step;
    logic       res_ld;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic clr_last;
  } sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

// File: rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: tape clear sweep, item accept, program reads, step, result hold.
// ----------------------------------------------------------------------------
module bfc_ctrl
  import bfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD0   = 3'd2;
  localparam logic [2:0] ST_RD1   = 3'd3;
  localparam logic [2:0] ST_RD2   = 3'd4;
  localparam logic [2:0] ST_STEP  = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (pend_r) begin
            cmd.res_ld = 1'b1;
            state_nxt  = ST_RESP;
          end else begin
            state_nxt = ST_IDLE;
          end
          pend_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          cmd.take = 1'b1;
          case (in_func)
            FUNC_LOAD: begin
              cmd.load   = 1'b1;
              cmd.res_ld = 1'b1;
              state_nxt  = ST_RESP;
            end
            FUNC_TICK: begin
              if (sts.halted) begin
                cmd.res_ld = 1'b1;
                state_nxt  = ST_RESP;
              end else begin
                state_nxt = ST_RD0;
              end
            end
            FUNC_RESTART: begin
              cmd.restart = 1'b1;
              pend_nxt    = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              cmd.res_ld = 1'b1;
              state_nxt  = ST_RESP;
            end
          endcase
        end
      end
      ST_RD0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_A0;
        cmd.tape_re = 1'b1;
        state_nxt   = ST_RD1;
      end
      ST_RD1: begin
        cmd.cap0   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_A1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.cap1   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_A2;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        cmd.res_ld = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_stall) |=> (state_r == ST_RESP))
    else $error("result dropped while stalled");

  a_step_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |=> (state_r == ST_RESP))
    else $error("step did not produce a result");

  a_rd_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD0) |=> (state_r == ST_RD1) ##1 (state_r == ST_RD2))
    else $error("program read sequence broken");

endmodule

// File: rtl/bfc_dpath.sv
// ----------------------------------------------------------------------------
// bfc_dpath
// Program store, tape, call stack, interpreter registers and step logic.
// ----------------------------------------------------------------------------
module bfc_dpath
  import bfc_pkg::*;
#(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
  parameter int CALL_DEPTH = CALL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  localparam int PA  = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int PCW = $clog2(PROG_DEPTH + 4);
  localparam int TA  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int SW  = $clog2(CALL_DEPTH + 1);
  localparam int SI  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

  logic [7:0]     prog_mem [PROG_DEPTH];
  logic [7:0]     tape_mem [TAPE_DEPTH];
  logic [PCW-1:0] ret_a [CALL_DEPTH];
  logic [PCW-1:0] fs_a  [CALL_DEPTH];
  logic [PCW-1:0] fe_a  [CALL_DEPTH];

  logic [7:0]     prog_q, tape_q, p0_r, p1_r, ib_r, p2;
  logic           poob_r, iv_r;
  logic [PCW-1:0] raddr;
  logic [TA-1:0]  clr_r;

  logic [PCW-1:0] pc_r, pc_nxt, nest_r, nest_nxt, fs_r, fs_nxt, fe_r, fe_nxt;
  logic [PCW-1:0] bs_r, bs_nxt, nsc;
  logic [TA-1:0]  dp_r, dp_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic [SW-1:0]  sl_r, sl_nxt;
  logic [7:0]     cn_r, cn_nxt;
  logic           halted_r, halted_nxt, fault_r, fault_nxt;

  logic           push, twe, at_end, in_ok, ov, od, wt;
  logic [7:0]     twd, sc_open, sc_close;
  logic [SI-1:0]  pop_i;
  out_item_t      res;

  assign p2     = poob_r ? 8'd0 : prog_q;
  assign pop_i  = SI'(sl_r - 1'b1);
  assign in_ok  = iv_r && !is_space(ib_r);
  assign at_end = (pc_r >= fe_r) || (pc_r >= PCW'(PROG_DEPTH)) || (p0_r == 8'd0);

  assign sts.halted   = halted_r;
  assign sts.clr_last = (clr_r == TA'(TAPE_DEPTH - 1));

  always_comb begin
    case (cmd.rd_sel)
      RD_A0:   raddr = (mode_r == M_SEARCH) ? pc_r - 1'b1 : pc_r;
      RD_A1:   raddr = (mode_r == M_SEARCH) ? pc_r - PCW'(2) : pc_r + 1'b1;
      default: raddr = pc_r + PCW'(2);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) prog_mem[PA'(in_data.load_addr)] <= in_data.load_byte;
    if (cmd.rd_en) begin
      prog_q <= prog_mem[raddr[PA-1:0]];
      poob_r <= (raddr >= PCW'(PROG_DEPTH));
    end
    if (cmd.cap0) p0_r <= p2;
    if (cmd.cap1) p1_r <= p2;
    if (cmd.take) begin
      ib_r <= in_data.in_byte;
      iv_r <= in_data.in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) tape_mem[clr_r] <= 8'd0;
    else if (twe && cmd.step) tape_mem[dp_r] <= twd;
    if (cmd.tape_re) tape_q <= tape_mem[dp_r];
  end

  always_ff @(posedge clk) begin
    if (push && cmd.step) begin
      ret_a[SI'(sl_r)] <= pc_r + PCW'(3);
      fs_a[SI'(sl_r)]  <= fs_r;
      fe_a[SI'(sl_r)]  <= fe_r;
    end
  end

  always_comb begin
    sc_open  = (mode_r == M_FWD) ? CH_LBRK : CH_LBRC;
    sc_close = (mode_r == M_FWD) ? CH_RBRK : CH_RBRC;
    if (mode_r == M_BACK) begin
      sc_open  = CH_RBRK;
      sc_close = CH_LBRK;
    end
    nsc = nest_r;
    if (p0_r == sc_open)  nsc = nsc + 1'b1;
    if (p0_r == sc_close) nsc = nsc - 1'b1;
  end

  always_comb begin
    pc_nxt = pc_r;  dp_nxt = dp_r;  mode_nxt = mode_r;  nest_nxt = nest_r;
    fs_nxt = fs_r;  fe_nxt = fe_r;  sl_nxt = sl_r;  cn_nxt = cn_r;  bs_nxt = bs_r;
    halted_nxt = halted_r;  fault_nxt = fault_r;
    push = 1'b0;  twe = 1'b0;  twd = tape_q;  ov = 1'b0;  od = 1'b0;  wt = 1'b0;
    case (mode_r)
      M_EXEC: begin
        if (at_end) begin
          if (sl_r == '0) begin
            halted_nxt = 1'b1;
          end else begin
            sl_nxt = sl_r - 1'b1;
            pc_nxt = ret_a[pop_i];
            fs_nxt = fs_a[pop_i];
            fe_nxt = fe_a[pop_i];
          end
        end else begin
          pc_nxt = pc_r + 1'b1;
          case (p0_r)
            CH_LT: dp_nxt = (dp_r == '0) ? TA'(TAPE_DEPTH - 1) : dp_r - 1'b1;
            CH_GT: dp_nxt = (dp_r == TA'(TAPE_DEPTH - 1)) ? '0 : dp_r + 1'b1;
            CH_PLUS: begin
              twe = 1'b1;
              twd = tape_q + 8'd1;
            end
            CH_MINUS: begin
              twe = 1'b1;
              twd = tape_q - 8'd1;
            end
            CH_DOT:  ov = 1'b1;
            CH_HASH: begin
              ov = 1'b1;
              od = 1'b1;
            end
            CH_COMMA: begin
              if (!in_ok) begin
                wt     = 1'b1;
                pc_nxt = pc_r;
              end else begin
                twe = 1'b1;
                twd = ib_r;
              end
            end
            CH_LBRK: begin
              if (tape_q == 8'd0) begin
                mode_nxt = M_FWD;
                nest_nxt = PCW'(1);
              end
            end
            CH_RBRK: begin
              if (pc_r > fs_r) begin
                mode_nxt = M_BACK;
                nest_nxt = PCW'(1);
                pc_nxt   = pc_r - 1'b1;
              end
            end
            CH_LBRC: begin
              if (is_alpha(p1_r) && p2 == CH_RBRC) begin
                pc_nxt = pc_r;
                if (sl_r >= SW'(CALL_DEPTH)) begin
                  fault_nxt  = 1'b1;
                  halted_nxt = 1'b1;
                end else begin
                  push     = 1'b1;
                  sl_nxt   = sl_r + 1'b1;
                  cn_nxt   = p1_r;
                  mode_nxt = M_SEARCH;
                end
              end else begin
                mode_nxt = M_SKIP;
                nest_nxt = PCW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      M_FWD, M_SKIP: begin
        if (at_end) begin
          mode_nxt = M_EXEC;
        end else begin
          nest_nxt = nsc;
          if (nsc == '0) begin
            mode_nxt = M_EXEC;
            if (mode_r == M_FWD) pc_nxt = pc_r + 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      M_BACK: begin
        nest_nxt = nsc;
        if (nsc == '0) begin
          mode_nxt = M_EXEC;
        end else if (pc_r <= fs_r) begin
          mode_nxt = M_EXEC;
          pc_nxt   = fs_r;
        end else begin
          pc_nxt = pc_r - 1'b1;
        end
      end
      M_SEARCH: begin
        if (pc_r <= fs_r) begin
          fault_nxt  = 1'b1;
          halted_nxt = 1'b1;
          mode_nxt   = M_EXEC;
        end else if (p0_r == CH_LBRC && pc_r > PCW'(1) && p1_r == cn_r) begin
          bs_nxt   = pc_r;
          nest_nxt = PCW'(1);
          mode_nxt = M_DEFEND;
        end else begin
          pc_nxt = pc_r - 1'b1;
        end
      end
      M_DEFEND: begin
        if (!at_end) nest_nxt = nsc;
        if (at_end || nsc == '0) begin
          fs_nxt   = bs_r;
          fe_nxt   = pc_r;
          pc_nxt   = bs_r;
          mode_nxt = M_EXEC;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      default: mode_nxt = M_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      pc_r     <= '0;
      dp_r     <= '0;
      mode_r   <= M_EXEC;
      nest_r   <= '0;
      fs_r     <= '0;
      fe_r     <= PCW'(PROG_DEPTH);
      sl_r     <= '0;
      cn_r     <= '0;
      bs_r     <= '0;
      halted_r <= 1'b0;
      fault_r  <= 1'b0;
      clr_r    <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.step) begin
        pc_r     <= pc_nxt;
        dp_r     <= dp_nxt;
        mode_r   <= mode_nxt;
        nest_r   <= nest_nxt;
        fs_r     <= fs_nxt;
        fe_r     <= fe_nxt;
        sl_r     <= sl_nxt;
        cn_r     <= cn_nxt;
        bs_r     <= bs_nxt;
        halted_r <= halted_nxt;
        fault_r  <= fault_nxt;
      end
    end
  end

  always_comb begin
    res = '0;
    if (cmd.step) begin
      res.out_valid     = ov;
      res.out_byte      = ov ? tape_q : 8'd0;
      res.out_decimal   = od;
      res.waiting_input = wt;
      res.halted        = halted_nxt;
      res.fault         = fault_nxt;
    end else begin
      res.halted = halted_r;
      res.fault  = fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) out_data <= res;
  end

  a_fault_halt: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> halted_r)
    else $error("fault without halt");

endmodule

// File: rtl/brainfuck_core_with_calls_core.sv
// ----------------------------------------------------------------------------
// brainfuck_core_with_calls_core
// Interpreter core with named calls: load, tick and restart items.
//
//   channel | ports                          | payload
//   in      | in_valid, in_stall, in_data    | in_item_t
//   out     | out_valid, out_stall, out_data | out_item_t
//
// A tick offers its result after three program store reads on its single
// port and then the step; a load, no-op or halted tick goes straight to it.
// The result is held until taken; the next item is accepted after that.
// Reset and restart sweep every tape cell to zero, stalling in meanwhile.
// ----------------------------------------------------------------------------
module brainfuck_core_with_calls_core
  import bfc_pkg::*;
#(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
  parameter int CALL_DEPTH = CALL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  bfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfc_dpath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .CALL_DEPTH (CALL_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: dv/brainfuck_core_with_calls_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_core_with_calls_core_tb
// Loads small programs and runs them one tick at a time, with input bytes
// offered at random. A local interpreter model predicts every result item
// and the checker compares the fields in order. Sender gaps and receiver
// stalls are random, and one long receiver stall fills the block.
// ----------------------------------------------------------------------------
module brainfuck_core_with_calls_core_tb;
  import bfc_pkg::*;

  localparam int PDEPTH = 1024;
  localparam int TDEPTH = 1024;
  localparam int CDEPTH = 8;
  localparam int IDLE_LIMIT = 40000;
  localparam int ITEM_GOAL = 1950;

  typedef enum logic [2:0] {
    ST_EXEC, ST_FWD, ST_BACK, ST_SEARCH, ST_DEFEND, ST_SKIP
  } scan_mode_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  brainfuck_core_with_calls_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // model state
  logic [7:0]  prog_mem [PDEPTH];
  logic [7:0]  cells [TDEPTH];
  int unsigned pc, dp, nest, fr_start, fr_end, level, body_at;
  logic [7:0]  callee;
  int unsigned ret_pc [CDEPTH];
  int unsigned ret_start [CDEPTH];
  int unsigned ret_end [CDEPTH];
  scan_mode_e  mode;
  logic        is_halted, is_fault;

  out_item_t   expected_q [$];
  int          errors;
  int          n_taken;
  int          n_sent;
  int          n_prints;
  int          n_faults;
  int          idle_cycles;
  bit          hold_off;
  bit          done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] prog_rd(int unsigned a);
    return (a < PDEPTH) ? prog_mem[a] : 8'd0;
  endfunction

  function automatic bit alpha_chr(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit blank_chr(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_run();
    foreach (cells[i]) cells[i] = 8'd0;
    pc = 0; dp = 0; nest = 0; fr_start = 0; fr_end = PDEPTH;
    level = 0; callee = 8'd0; body_at = 0; mode = ST_EXEC;
    is_halted = 1'b0; is_fault = 1'b0;
  endfunction

  function automatic void raise_fault();
    is_fault = 1'b1; is_halted = 1'b1; mode = ST_EXEC;
  endfunction

  // forward scan over one cell; returns 1 when nesting closes, sets open_end
  function automatic bit fwd_cell(logic [7:0] op, logic [7:0] cl, output bit open_end);
    logic [7:0] c;
    open_end = 1'b0;
    if (pc >= fr_end || pc >= PDEPTH || prog_rd(pc) == 8'd0) begin
      open_end = 1'b1;
      return 1'b0;
    end
    c = prog_rd(pc);
    if (c == op) nest++;
    if (c == cl) nest--;
    return nest == 0;
  endfunction

  function automatic void run_instr(input in_item_t it, inout out_item_t r);
    int unsigned p;
    logic [7:0] c;
    p = pc;
    if (p >= fr_end || p >= PDEPTH || prog_rd(p) == 8'd0) begin
      if (level == 0) is_halted = 1'b1;
      else begin
        level--;
        pc = ret_pc[level]; fr_start = ret_start[level]; fr_end = ret_end[level];
      end
      return;
    end
    c = prog_rd(p);
    case (c)
      CH_LT: dp = (dp == 0) ? TDEPTH - 1 : dp - 1;
      CH_GT: dp = (dp + 1) % TDEPTH;
      CH_PLUS: cells[dp] = cells[dp] + 8'd1;
      CH_MINUS: cells[dp] = cells[dp] - 8'd1;
      CH_DOT: begin
        r.out_valid = 1'b1; r.out_byte = cells[dp];
      end
      CH_HASH: begin
        r.out_valid = 1'b1; r.out_byte = cells[dp]; r.out_decimal = 1'b1;
      end
      CH_COMMA: begin
        if (!(it.in_valid && !blank_chr(it.in_byte))) begin
          r.waiting_input = 1'b1;
          return;
        end
        cells[dp] = it.in_byte;
      end
      CH_LBRK: if (cells[dp] == 8'd0) begin
        mode = ST_FWD; nest = 1;
      end
      CH_RBRK: if (p > fr_start) begin
        mode = ST_BACK; nest = 1; pc = p - 1;
        return;
      end
      CH_LBRC: begin
        if (alpha_chr(prog_rd(p + 1)) && prog_rd(p + 2) == CH_RBRC) begin
          if (level >= CDEPTH) begin
            raise_fault();
            return;
          end
          ret_pc[level] = p + 3; ret_start[level] = fr_start; ret_end[level] = fr_end;
          level++;
          callee = prog_rd(p + 1);
          mode = ST_SEARCH;
          return;
        end
        mode = ST_SKIP; nest = 1;
      end
      default: ;
    endcase
    pc = p + 1;
  endfunction

  function automatic void tick_model(input in_item_t it, inout out_item_t r);
    bit oe;
    int unsigned p;
    logic [7:0] c;
    p = pc;
    if (is_halted) return;
    case (mode)
      ST_EXEC: run_instr(it, r);
      ST_FWD: begin
        if (fwd_cell(CH_LBRK, CH_RBRK, oe)) begin
          mode = ST_EXEC; pc = p + 1;
        end else if (oe) mode = ST_EXEC;
        else pc = p + 1;
      end
      ST_SKIP: begin
        if (fwd_cell(CH_LBRC, CH_RBRC, oe) || oe) mode = ST_EXEC;
        else pc = p + 1;
      end
      ST_BACK: begin
        c = prog_rd(p);
        if (c == CH_LBRK) nest--;
        if (c == CH_RBRK) nest++;
        if (nest == 0) mode = ST_EXEC;
        else if (p <= fr_start) begin
          mode = ST_EXEC; pc = fr_start;
        end else pc = p - 1;
      end
      ST_SEARCH: begin
        if (p <= fr_start) raise_fault();
        else begin
          p--;
          pc = p;
          if (prog_rd(p) == CH_LBRC && p > 0 && prog_rd(p - 1) == callee) begin
            body_at = p + 1; pc = p + 1; nest = 1; mode = ST_DEFEND;
          end
        end
      end
      ST_DEFEND: begin
        if (fwd_cell(CH_LBRC, CH_RBRC, oe) || oe) begin
          fr_start = body_at; fr_end = p; pc = body_at; mode = ST_EXEC;
        end else pc = p + 1;
      end
      default: mode = ST_EXEC;
    endcase
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.func == FUNC_LOAD) prog_mem[it.load_addr] = it.load_byte;
    else if (it.func == FUNC_TICK) tick_model(it, r);
    else if (it.func == FUNC_RESTART) clear_run();
    r.halted = is_halted;
    r.fault = is_fault;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s at result %0d: got %0h want %0h", what, n_taken, got, want);
  endtask

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    expected_q.push_back(predict_step(it));
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // burst-mode variant: keep valid high across items
  task automatic send_quiet(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    expected_q.push_back(predict_step(it));
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] f, int unsigned a, logic [7:0] b);
    in_item_t it;
    it.func = f;
    it.load_addr = a[9:0];
    it.load_byte = b;
    it.in_byte = 8'($urandom_range(0, 255));
    it.in_valid = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(mk(FUNC_LOAD, i, s[i]));
    send_item(mk(FUNC_LOAD, s.len(), 8'd0));
  endtask

  task automatic run_ticks(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = mk(FUNC_TICK, $urandom, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0) it.in_byte = 8'($urandom_range(9, 13));
      send_item(it);
      if (is_halted && $urandom_range(0, 3) == 0) break;
    end
  endtask

  task automatic test_basic_ops();
    in_item_t it;
    load_text("+++.-#<.>>-#,.,#[-]#");
    send_item(mk(FUNC_RESTART, 0, 0));
    for (int i = 0; i < 22; i++) begin
      it = mk(FUNC_TICK, 10'h3FF, 8'hFF);
      it.in_valid = (i % 3 != 0);
      it.in_byte = (i == 10) ? 8'd32 : (i == 13 ? 8'hFF : 8'h80);
      send_item(it);
    end
    send_item(mk(FUNC_LOAD, 1023, 8'hFF));
    send_item(mk(FUNC_LOAD, 1023, 8'h00));
    send_item(mk(FUNC_NOP, 0, 0));
  endtask

  task automatic test_calls();
    send_item(mk(FUNC_RESTART, 0, 0));
    load_text("a{+.}b{{a}#}{b}{a}]{z}");
    run_ticks(80);
    send_item(mk(FUNC_RESTART, 0, 0));
    load_text("r{{r}}{r}");
    run_ticks(200);
  endtask

  task automatic test_long_stall();
    send_item(mk(FUNC_RESTART, 0, 0));
    load_text("+[.+]");
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_quiet(mk(FUNC_TICK, 0, 0));
  endtask

  function automatic logic [7:0] rand_op();
    logic [7:0] ops [14];
    ops = '{CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_DOT, CH_HASH, CH_COMMA,
            CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC, "a", "b", CH_PLUS};
    return ops[$urandom_range(0, 13)];
  endfunction

  task automatic test_random_programs();
    int len;
    string s;
    logic [7:0] nm;
    while (n_sent < ITEM_GOAL) begin
      send_item(mk(FUNC_RESTART, 0, 0));
      s = "";
      len = $urandom_range(4, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          nm = $urandom_range(0, 1) ? "a" : "b";
          if ($urandom_range(0, 1)) s = {s, string'(nm), "{+.#}"};
          else s = {s, "{", string'(nm), "}"};
        end else if ($urandom_range(0, 7) == 0) s = {s, "[-.]"};
        else s = {s, string'(rand_op())};
      end
      if ($urandom_range(0, 15) == 0)
        send_item(mk(FUNC_LOAD, $urandom_range(0, 1023), 8'($urandom_range(0, 255))));
      load_text(s);
      len = $urandom_range(10, 90);
      run_ticks(len);
    end
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(0, 9) < 3 && n_taken % 200 > 60);
  end

  initial begin
    int cnt;
    wait (hold_off);
    cnt = 0;
    while (cnt < 150) begin
      @(posedge clk);
      cnt++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report_mismatch("unexpected", int'(out_data), 0);
      else begin
        want = expected_q.pop_front();
        if (out_data.out_valid !== want.out_valid)
          report_mismatch("out_valid", out_data.out_valid, want.out_valid);
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.out_decimal !== want.out_decimal)
          report_mismatch("out_decimal", out_data.out_decimal, want.out_decimal);
        if (out_data.waiting_input !== want.waiting_input)
          report_mismatch("waiting_input", out_data.waiting_input, want.waiting_input);
        if (out_data.halted !== want.halted)
          report_mismatch("halted", out_data.halted, want.halted);
        if (out_data.fault !== want.fault)
          report_mismatch("fault", out_data.fault, want.fault);
        if (want.out_valid) n_prints++;
        if (want.fault) n_faults++;
      end
      n_taken++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !done) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    done = 1'b0;
    errors = 0; n_taken = 0; n_sent = 0; n_prints = 0; n_faults = 0; idle_cycles = 0;
    foreach (prog_mem[i]) prog_mem[i] = 8'd0;
    clear_run();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_calls();
    test_long_stall();
    test_random_programs();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    done = 1'b1;
    $display("covered %0d results, %0d prints, %0d faulted steps", n_taken, n_prints, n_faults);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
